>>> hdl/wavh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and table functions for the WAV header validator.
// Used by the capture unit, the check unit and the top level; depends on nothing.
package wavh_pkg;

	// Header geometry.
	localparam int HEADER_LENGTH = 44;
	localparam int POS_W         = $clog2(HEADER_LENGTH + 1);

	// Serial remainder unit: one dividend bit per step.
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Configuration register indexes and reset values.
	localparam logic REG_RATE  = 1'b0;
	localparam logic REG_DEPTH = 1'b1;
	localparam logic [31:0] RATE_RESET  = 32'd16000;
	localparam logic [15:0] DEPTH_RESET = 16'd16;

	// Fixed header values that enter the final checks.
	localparam logic [31:0] RIFF_OVERHEAD = 32'd8;
	localparam logic [15:0] CHANNELS_MONO   = 16'd1;
	localparam logic [15:0] CHANNELS_STEREO = 16'd2;

	// Snapshot of the captured header, as it stands after the current byte.
	typedef struct packed {
		logic        full;
		logic        good;
		logic [31:0] riff_length;
		logic [31:0] rate;
		logic [15:0] channels;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] data_length;
	} cap_t;

	// One verdict with its decoded fields.
	typedef struct packed {
		logic        ok;
		logic [31:0] payload_bytes;
		logic [31:0] rate_hz;
		logic [1:0]  channel_count;
		logic [15:0] sample_bits;
	} res_t;

	// True where the header byte at this position has a fixed value.
	function automatic logic check_byte(input logic [POS_W-1:0] pos);
		logic hit;
		hit = 1'b0;
		case (pos) inside
			[6'd0:6'd3], [6'd8:6'd21], [6'd36:6'd39]: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// The fixed value of the header byte at this position.
	function automatic logic [7:0] want_byte(input logic [POS_W-1:0] pos);
		logic [7:0] b;
		b = 8'h00;
		case (pos)
			6'd0:  b = "R";
			6'd1:  b = "I";
			6'd2:  b = "F";
			6'd3:  b = "F";
			6'd8:  b = "W";
			6'd9:  b = "A";
			6'd10: b = "V";
			6'd11: b = "E";
			6'd12: b = "f";
			6'd13: b = "m";
			6'd14: b = "t";
			6'd15: b = " ";
			6'd16: b = 8'd16;
			6'd20: b = 8'd1;
			6'd36: b = "d";
			6'd37: b = "a";
			6'd38: b = "t";
			6'd39: b = "a";
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> hdl/wavh_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for header bytes and verdicts.
// Depends on nothing but the language.
interface wavh_hdr_if;
	logic        valid;
	logic        ready;
	logic [7:0]  header_byte;
	logic        final_byte;
	logic [63:0] total_file_size;

	modport source (output valid, header_byte, final_byte, total_file_size, input ready);
	modport sink   (input valid, header_byte, final_byte, total_file_size, output ready);
endinterface

interface wavh_res_if;
	logic        valid;
	logic        ready;
	logic        header_ok;
	logic [31:0] payload_bytes;
	logic [31:0] rate_hz;
	logic [1:0]  channel_count;
	logic [15:0] sample_bits;

	modport source (output valid, header_ok, payload_bytes, rate_hz, channel_count,
		sample_bits, input ready);
	modport sink   (input valid, header_ok, payload_bytes, rate_hz, channel_count,
		sample_bits, output ready);
endinterface

>>> hdl/wav_header_validator_top.sv
`timescale 1ns / 1ps
// Top level of the WAV header validator: configuration registers, the
// output register and the capture and check units. Depends on wavh_pkg and wavh_if.
//
// Usage: header bytes arrive on the hdr channel in file order, one per
// transfer, with final_byte set and total_file_size valid on the last one.
// Bytes after the 44th are counted out and ignored. A transfer with final_byte
// set produces exactly one verdict on the res channel. The verdict passes through
// a setup state, the steps of the bit-serial remainder unit that tests the data
// length against the block alignment, a done state and the output register.
// While the check runs, hdr.ready is low; bytes of the next header are taken again
// as soon as the verdict has moved to the output register, even if res.ready is
// low. If res.ready stays low and a second verdict is complete, the check unit
// holds it and hdr.ready stays low until the first verdict is taken.
// Reset clears the byte position, the capture and the output valid flag, and
// sets expected_rate to 16000 and expected_depth to 16. The APB port at byte
// address 0 holds expected_rate and at 4 expected_depth; write only while idle.
module wav_header_validator_top (
	input  logic              clk,
	input  logic              arst_n,
	wavh_hdr_if.sink          hdr,
	wavh_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0]     exp_rate_q;
	logic [15:0]     exp_depth_q;
	logic            out_valid_q;
	wavh_pkg::res_t  out_q;

	logic            hdr_take;
	logic            launch;
	logic            chk_busy;
	logic            chk_valid;
	logic            chk_take;
	wavh_pkg::cap_t  snap;
	wavh_pkg::res_t  chk_res;

	assign pready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_rate_q  <= wavh_pkg::RATE_RESET;
			exp_depth_q <= wavh_pkg::DEPTH_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				wavh_pkg::REG_RATE:  exp_rate_q  <= pwdata;
				wavh_pkg::REG_DEPTH: exp_depth_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Configuration reads.
	always_comb begin
		unique case (paddr[2])
			wavh_pkg::REG_RATE:  prdata = exp_rate_q;
			wavh_pkg::REG_DEPTH: prdata = {16'd0, exp_depth_q};
			default:             prdata = '0;
		endcase
	end

	// Input transfers are taken whenever the check unit is free.
	assign hdr.ready = !chk_busy;
	assign hdr_take  = hdr.valid && hdr.ready;
	assign launch    = hdr_take && hdr.final_byte;

	wavh_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (hdr_take),
		.header_byte (hdr.header_byte),
		.final_byte  (hdr.final_byte),
		.snap        (snap)
	);

	wavh_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.launch     (launch),
		.snap       (snap),
		.total_size (hdr.total_file_size),
		.exp_rate   (exp_rate_q),
		.exp_depth  (exp_depth_q),
		.busy       (chk_busy),
		.res_valid  (chk_valid),
		.res_take   (chk_take),
		.res        (chk_res)
	);

	// Output register between the check unit and the receiver.
	assign chk_take = chk_valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chk_take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chk_take) begin
			out_q <= chk_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.header_ok     = out_q.ok;
	assign res.payload_bytes = out_q.payload_bytes;
	assign res.rate_hz       = out_q.rate_hz;
	assign res.channel_count = out_q.channel_count;
	assign res.sample_bits   = out_q.sample_bits;

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chk_busy |-> !hdr.ready)
		else $error("header byte taken while the check unit is busy");
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		chk_take |=> res.valid)
		else $error("verdict left the check unit but the output is empty");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !chk_take)
		else $error("pending verdict overwritten");
`endif

endmodule

>>> hdl/wavh_capture.sv
`timescale 1ns / 1ps
// Byte-serial capture of the header fields and the magic/format check.
// Depends on wavh_pkg.
module wavh_capture (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [7:0]                header_byte,
	input  logic                      final_byte,
	output wavh_pkg::cap_t            snap
);

	logic [wavh_pkg::POS_W-1:0] pos_q;
	logic                       good_q;
	logic [31:0]                riff_q;
	logic [31:0]                rate_q;
	logic [15:0]                chan_q;
	logic [15:0]                align_q;
	logic [15:0]                bits_q;
	logic [31:0]                dlen_q;

	logic                       in_header;
	logic [4:0]                 lane32;
	logic [3:0]                 lane16;

	assign in_header = (pos_q < wavh_pkg::POS_W'(wavh_pkg::HEADER_LENGTH));
	assign lane32    = {pos_q[1:0], 3'b000};
	assign lane16    = {pos_q[0], 3'b000};

	// The header as it stands once the current byte has been merged in.
	always_comb begin
		snap.full        = (pos_q >= wavh_pkg::POS_W'(wavh_pkg::HEADER_LENGTH - 1));
		snap.good        = good_q;
		snap.riff_length = riff_q;
		snap.rate        = rate_q;
		snap.channels    = chan_q;
		snap.align       = align_q;
		snap.bits        = bits_q;
		snap.data_length = dlen_q;
		if (in_header) begin
			if (wavh_pkg::check_byte(pos_q) && (header_byte != wavh_pkg::want_byte(pos_q))) begin
				snap.good = 1'b0;
			end
			case (pos_q) inside
				[6'd4:6'd7]:   snap.riff_length[lane32 +: 8] = header_byte;
				[6'd22:6'd23]: snap.channels[lane16 +: 8]    = header_byte;
				[6'd24:6'd27]: snap.rate[lane32 +: 8]        = header_byte;
				[6'd32:6'd33]: snap.align[lane16 +: 8]       = header_byte;
				[6'd34:6'd35]: snap.bits[lane16 +: 8]        = header_byte;
				[6'd40:6'd43]: snap.data_length[lane32 +: 8] = header_byte;
				default: ;
			endcase
		end
	end

	// Position counter and field registers; everything clears when a final byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			good_q  <= 1'b1;
			riff_q  <= '0;
			rate_q  <= '0;
			chan_q  <= '0;
			align_q <= '0;
			bits_q  <= '0;
			dlen_q  <= '0;
		end else if (take) begin
			if (final_byte) begin
				pos_q   <= '0;
				good_q  <= 1'b1;
				riff_q  <= '0;
				rate_q  <= '0;
				chan_q  <= '0;
				align_q <= '0;
				bits_q  <= '0;
				dlen_q  <= '0;
			end else begin
				if (in_header) begin
					pos_q <= pos_q + 1'b1;
				end
				good_q  <= snap.good;
				riff_q  <= snap.riff_length;
				rate_q  <= snap.rate;
				chan_q  <= snap.channels;
				align_q <= snap.align;
				bits_q  <= snap.bits;
				dlen_q  <= snap.data_length;
			end
		end
	end

endmodule

>>> hdl/wavh_check.sv
`timescale 1ns / 1ps
// Final checks on a captured header, with a bit-serial remainder unit for
// the block alignment test. Depends on wavh_pkg.
module wavh_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 launch,
	input  wavh_pkg::cap_t       snap,
	input  logic [63:0]          total_size,
	input  logic [31:0]          exp_rate,
	input  logic [15:0]          exp_depth,
	output logic                 busy,
	output logic                 res_valid,
	input  logic                 res_take,
	output wavh_pkg::res_t       res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                  state_q;
	logic [wavh_pkg::STEP_W-1:0] step_q;
	wavh_pkg::cap_t              cap_q;
	logic [63:0]                 fsize_q;
	logic                        pre_ok_q;
	logic                        size_a_q;
	logic                        size_b_q;
	logic [15:0]                 div_q;
	logic [15:0]                 rem_q;
	logic [31:0]                 shift_q;

	logic [15:0] align_needed;
	logic [16:0] trial;
	logic [16:0] trial_sub;
	logic        verdict_ok;

	// Alignment implied by the channel count and sample width.
	always_comb begin
		if (cap_q.channels == wavh_pkg::CHANNELS_STEREO) begin
			align_needed = {cap_q.bits[15:3], 3'b000} >> 2;
		end else begin
			align_needed = {3'b000, cap_q.bits[15:3]};
		end
	end

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	assign trial     = {rem_q, shift_q[31]};
	assign trial_sub = trial - {1'b0, div_q};

	assign verdict_ok = pre_ok_q && size_a_q && size_b_q && (rem_q == '0);

	// Sequencer for setup, the remainder steps and the held verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_RUN;
					step_q  <= '0;
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == wavh_pkg::STEP_W'(wavh_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers for the captured header and the partial results.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && launch) begin
			cap_q   <= snap;
			fsize_q <= total_size;
		end
		if (state_q == ST_SETUP) begin
			pre_ok_q <= cap_q.full && cap_q.good && (cap_q.data_length != '0)
				&& (cap_q.rate == exp_rate) && (cap_q.bits == exp_depth)
				&& ((cap_q.channels == wavh_pkg::CHANNELS_MONO)
					|| (cap_q.channels == wavh_pkg::CHANNELS_STEREO))
				&& (align_needed != '0) && (cap_q.align == align_needed);
			size_a_q <= (fsize_q == ({32'd0, cap_q.data_length}
				+ 64'(wavh_pkg::HEADER_LENGTH)));
			div_q    <= align_needed;
			rem_q    <= '0;
			shift_q  <= cap_q.data_length;
		end
		if (state_q == ST_RUN) begin
			if (step_q == '0) begin
				size_b_q <= (fsize_q == ({32'd0, cap_q.riff_length}
					+ {32'd0, wavh_pkg::RIFF_OVERHEAD}));
			end
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial_sub[15:0];
			end else begin
				rem_q <= trial[15:0];
			end
			shift_q <= {shift_q[30:0], 1'b0};
		end
	end

	// Verdict, with the decoded fields forced to zero on failure.
	always_comb begin
		res.ok            = verdict_ok;
		res.payload_bytes = verdict_ok ? cap_q.data_length : '0;
		res.rate_hz       = verdict_ok ? cap_q.rate : '0;
		res.channel_count = verdict_ok ? cap_q.channels[1:0] : '0;
		res.sample_bits   = verdict_ok ? cap_q.bits : '0;
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

`ifndef SYNTHESIS
	a_launch_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && launch) |=> (state_q == ST_SETUP))
		else $error("check unit did not start after a final byte");
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == wavh_pkg::STEP_W'(wavh_pkg::DIV_STEPS - 1))
		|=> (state_q == ST_DONE))
		else $error("remainder steps did not end in the verdict state");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && div_q != '0) |-> (rem_q < div_q))
		else $error("partial remainder not below the divisor");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.ok) |-> (res.payload_bytes == '0 && res.rate_hz == '0
			&& res.channel_count == '0 && res.sample_bits == '0))
		else $error("failed verdict carries nonzero fields");
`endif

endmodule

>>> test/wavh_checker.sv
`timescale 1ns / 1ps
// Passive checker for the WAV header validator: it mirrors the register writes, checks
// register reads, predicts a verdict for every header and compares the results.
// Depends on wavh_pkg and on the channel interfaces in wavh_if.
module wavh_checker (
	input  logic        clk,
	input  logic        arst_n,
	wavh_hdr_if         hdr,
	wavh_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned verdict_count,
	output int unsigned accept_count
);

	// Canonical header image, byte 0 in the top lane, and the positions whose value is fixed.
	localparam logic [8*wavh_pkg::HEADER_LENGTH-1:0] CANON = {"RIFF", 32'h0, "WAVEfmt ",
		8'd16, 24'h0, 8'd1, 8'h0, 112'h0, "data", 32'h0};
	localparam logic [wavh_pkg::HEADER_LENGTH-1:0] FIXED_MASK = 44'h0F0003FFF0F;
	localparam int REPORT_LIMIT = 10;

	logic [31:0]                want_rate;
	logic [15:0]                want_depth;
	logic [wavh_pkg::POS_W-1:0] hdr_seen;
	logic                       fixed_ok;
	logic [31:0]                hdr_riff;
	logic [31:0]                hdr_rate;
	logic [15:0]                hdr_chans;
	logic [15:0]                hdr_align;
	logic [15:0]                hdr_bits;
	logic [31:0]                hdr_data;
	wavh_pkg::res_t             verdict_q[$];
	int unsigned                mismatches;
	int unsigned                verdicts;
	int unsigned                accepts;

	// Forget the header in progress; the registers are kept.
	task automatic clear_header();
		hdr_seen  = '0;
		fixed_ok  = 1'b1;
		hdr_riff  = '0;
		hdr_rate  = '0;
		hdr_chans = '0;
		hdr_align = '0;
		hdr_bits  = '0;
		hdr_data  = '0;
	endtask

	// Verdict on the captured header for the file size given with the final byte.
	function automatic wavh_pkg::res_t judge(input logic [63:0] fsize);
		wavh_pkg::res_t r;
		logic [31:0]    frame;
		r = '0;
		if (hdr_seen < wavh_pkg::HEADER_LENGTH || !fixed_ok)
			return r;
		if (fsize < 64'(wavh_pkg::HEADER_LENGTH))
			return r;
		if (hdr_data == 32'd0 || hdr_rate != want_rate || hdr_bits != want_depth)
			return r;
		if (hdr_chans != wavh_pkg::CHANNELS_MONO && hdr_chans != wavh_pkg::CHANNELS_STEREO)
			return r;
		frame = (32'(hdr_chans) * (32'(hdr_bits) / 32'd8)) & 32'h0000_FFFF;
		if (frame == 32'd0 || 32'(hdr_align) != frame)
			return r;
		if (hdr_data % frame != 32'd0)
			return r;
		if (64'(wavh_pkg::HEADER_LENGTH) + 64'(hdr_data) != fsize)
			return r;
		if (64'(hdr_riff) + 64'(wavh_pkg::RIFF_OVERHEAD) != fsize)
			return r;
		r.ok            = 1'b1;
		r.payload_bytes = hdr_data;
		r.rate_hz       = hdr_rate;
		r.channel_count = hdr_chans[1:0];
		r.sample_bits   = hdr_bits;
		return r;
	endfunction

	// Capture one header byte; a final byte closes the header with a verdict.
	task automatic absorb(input logic [7:0] b, input logic fin, input logic [63:0] fsize);
		int p;
		p = int'(hdr_seen);
		if (p < wavh_pkg::HEADER_LENGTH) begin
			if (FIXED_MASK[p] && b != CANON[8*(wavh_pkg::HEADER_LENGTH-1-p) +: 8])
				fixed_ok = 1'b0;
			case (p)
				4, 5, 6, 7:     hdr_riff[8*(p-4) +: 8] = b;
				22, 23:         hdr_chans[8*(p-22) +: 8] = b;
				24, 25, 26, 27: hdr_rate[8*(p-24) +: 8] = b;
				32, 33:         hdr_align[8*(p-32) +: 8] = b;
				34, 35:         hdr_bits[8*(p-34) +: 8] = b;
				40, 41, 42, 43: hdr_data[8*(p-40) +: 8] = b;
				default: ;
			endcase
			hdr_seen = hdr_seen + 1'b1;
		end
		if (fin) begin
			verdict_q.push_back(judge(fsize));
			verdicts++;
			clear_header();
		end
	endtask

	// Compare one verdict transfer with the oldest prediction.
	task automatic compare(input wavh_pkg::res_t got);
		wavh_pkg::res_t want;
		if (verdict_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: verdict with none predicted: ok=%0b bytes=%0d rate=%0d ch=%0d bits=%0d",
					$realtime, got.ok, got.payload_bytes, got.rate_hz, got.channel_count,
					got.sample_bits);
			return;
		end
		want = verdict_q.pop_front();
		if (want.ok) accepts++;
		if (got.ok != want.ok || got.payload_bytes != want.payload_bytes ||
				got.rate_hz != want.rate_hz || got.channel_count != want.channel_count ||
				got.sample_bits != want.sample_bits) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%0t: verdict mismatch, expected ok=%0b bytes=%0d rate=%0d ch=%0d bits=%0d",
					$realtime, want.ok, want.payload_bytes, want.rate_hz, want.channel_count,
					want.sample_bits);
				$display("%0t:                     got ok=%0b bytes=%0d rate=%0d ch=%0d bits=%0d",
					$realtime, got.ok, got.payload_bytes, got.rate_hz, got.channel_count,
					got.sample_bits);
			end
		end
	endtask

	// Register reads must return the value last written.
	task automatic check_read();
		logic [31:0] want;
		logic [31:0] seen;
		if (paddr[2] == wavh_pkg::REG_RATE) begin
			want = want_rate;
			seen = prdata;
		end else begin
			want = 32'(want_depth);
			seen = 32'(prdata[15:0]);
		end
		if (seen != want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: register read at %0d, expected %0d, got %0d",
					$realtime, paddr, want, seen);
		end
	endtask

	// Everything is sampled at the rising edge, before the edge's updates land.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_rate  = wavh_pkg::RATE_RESET;
			want_depth = wavh_pkg::DEPTH_RESET;
			clear_header();
			verdict_q.delete();
			mismatches = 0;
			verdicts   = 0;
			accepts    = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == wavh_pkg::REG_RATE)
						want_rate = pwdata;
					else
						want_depth = pwdata[15:0];
				end else begin
					check_read();
				end
			end
			if (hdr.valid && hdr.ready)
				absorb(hdr.header_byte, hdr.final_byte, hdr.total_file_size);
			if (res.valid && res.ready)
				compare('{ok: res.header_ok, payload_bytes: res.payload_bytes,
					rate_hz: res.rate_hz, channel_count: res.channel_count,
					sample_bits: res.sample_bits});
		end
		fail_count    <= mismatches;
		pending       <= verdict_q.size();
		verdict_count <= verdicts;
		accept_count  <= accepts;
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the WAV header validator: clock, reset, header and register
// stimulus, and the verdict. Depends on wavh_pkg, wavh_if, the RTL and wavh_checker.
module tb_top;

	localparam int CLK_HALF_NS   = 1;
	localparam int LIMIT_NS      = 2_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int BYTES_PER_SET = 90;
	localparam int HDRS_PER_SET  = 2;
	localparam int NO_FLIP       = -1;
	localparam int SCRAMBLE      = -2;
	localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
	localparam logic [15:0] FORMAT_PCM    = 16'd1;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned verdict_count;
	int unsigned accept_count;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned bytes_sent     = 0;
	int unsigned settings       = 1;
	logic [31:0] cur_rate       = wavh_pkg::RATE_RESET;
	logic [15:0] cur_depth      = wavh_pkg::DEPTH_RESET;

	wavh_hdr_if hdr ();
	wavh_res_if res ();

	wav_header_validator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr     (hdr),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	wavh_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.hdr           (hdr),
		.res           (res),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.verdict_count (verdict_count),
		.accept_count  (accept_count)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Watchdog for a block that stops answering.
	initial begin
		#(LIMIT_NS);
		$display("FAIL wav_header_validator_top");
		$finish;
	end

	// The verdict receiver stalls at the rate of the current idling phase.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] le32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [15:0] le16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	task automatic idle_phase(input int k);
		case (k)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 80;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 80;
			end
			default: begin
				send_idle_pct  = 32;
				recv_stall_pct = 32;
			end
		endcase
	endtask

	// One byte transfer, after a random idle gap; valid stays high for the next byte.
	task automatic put_byte(input logic [7:0] b, input logic fin, input logic [63:0] fsize);
		while ($urandom_range(99) < send_idle_pct) begin
			hdr.valid <= 1'b0;
			@(posedge clk);
		end
		hdr.valid           <= 1'b1;
		hdr.header_byte     <= b;
		hdr.final_byte      <= fin;
		hdr.total_file_size <= fsize;
		@(posedge clk);
		while (!hdr.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Send len bytes of a header built from these fields; bytes past the header are random.
	task automatic send_wav(input logic [31:0] rate, input logic [15:0] chans,
			input logic [15:0] bits, input logic [15:0] align, input logic [31:0] dlen,
			input logic [31:0] riff, input logic [63:0] fsize, input int len, input int flip);
		logic [8*wavh_pkg::HEADER_LENGTH-1:0] img;
		logic [7:0]                           b;
		logic                                 fin;
		img = {"RIFF", le32(riff), "WAVEfmt ", le32(FMT_CHUNK_LEN), le16(FORMAT_PCM),
			le16(chans), le32(rate), le32($urandom), le16(align), le16(bits), "data",
			le32(dlen)};
		if (flip == SCRAMBLE)
			img = {11{$urandom}};
		else if (flip >= 0)
			img[8*(wavh_pkg::HEADER_LENGTH-1-flip) +: 8] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < len; i++) begin
			fin = (i == len - 1);
			b = (i < wavh_pkg::HEADER_LENGTH) ?
				img[8*(wavh_pkg::HEADER_LENGTH-1-i) +: 8] : 8'($urandom);
			put_byte(b, fin, fin ? fsize : {$urandom, $urandom});
		end
	endtask

	// Stop sending and wait for every predicted verdict, then let the block settle.
	task automatic drain();
		hdr.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register transfer: a setup phase, then an access phase.
	task automatic reg_access(input logic wr, input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [31:0] rate, input logic [15:0] depth);
		drain();
		reg_access(1'b1, wavh_pkg::REG_RATE, rate);
		reg_access(1'b1, wavh_pkg::REG_DEPTH, {16'($urandom), depth});
		reg_access(1'b0, wavh_pkg::REG_RATE, 32'd0);
		reg_access(1'b0, wavh_pkg::REG_DEPTH, 32'd0);
		cur_rate  = rate;
		cur_depth = depth;
		settings++;
	endtask

	// Mostly well-formed headers for the current registers, with one fault now and then.
	task automatic random_header();
		logic [15:0] chans;
		logic [15:0] bits;
		logic [15:0] align;
		logic [31:0] rate;
		logic [31:0] dlen;
		logic [31:0] riff;
		logic [63:0] fsize;
		int          kind;
		int          len;
		int          flip;
		int          idx;
		kind  = $urandom_range(0, 31);
		chans = 16'($urandom_range(1, 2));
		rate  = cur_rate;
		bits  = cur_depth;
		flip  = NO_FLIP;
		case (kind)
			16: chans = $urandom_range(1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
			17: rate = $urandom_range(1) ? $urandom : rate ^ (32'd1 << $urandom_range(31));
			18: bits = 16'($urandom_range(0, 40));
			default: ;
		endcase
		align = 16'(32'(chans) * 32'(bits / 16'd8));
		if ($urandom_range(7) == 0)
			dlen = $urandom;
		else
			dlen = 32'(align) * 32'($urandom_range(1, 3000));
		case (kind)
			19: align = 16'($urandom);
			20: dlen = dlen + 32'($urandom_range(1, 3));
			21: dlen = 32'd0;
			default: ;
		endcase
		riff  = dlen + 32'd36;
		fsize = 64'(wavh_pkg::HEADER_LENGTH) + 64'(dlen);
		case (kind)
			22: riff = riff ^ (32'd1 << $urandom_range(31));
			23: fsize = {$urandom, $urandom};
			24: fsize = 64'($urandom_range(0, wavh_pkg::HEADER_LENGTH - 1));
			default: ;
		endcase
		len = ($urandom_range(3) == 0) ? wavh_pkg::HEADER_LENGTH + $urandom_range(1, 8)
			: wavh_pkg::HEADER_LENGTH;
		case (kind)
			25, 26: begin
				// Pick one of the positions that hold a magic word or a format value.
				idx  = $urandom_range(0, 21);
				flip = (idx < 4) ? idx : (idx < 18) ? idx + 4 : idx + 18;
			end
			27: len = $urandom_range(1, wavh_pkg::HEADER_LENGTH - 1);
			28: begin
				flip  = SCRAMBLE;
				len   = $urandom_range(1, 60);
				fsize = {$urandom, $urandom};
			end
			default: ;
		endcase
		send_wav(rate, chans, bits, align, dlen, riff, fsize, len, flip);
	endtask

	initial begin
		logic [31:0] set_rate [8];
		logic [15:0] set_depth [8];
		int unsigned mark;
		int          n;
		set_rate  = '{32'd16000, 32'd44100, 32'd48000, 32'd8000, 32'd0, 32'hFFFF_FFFF,
			32'd22050, 32'd96000};
		set_depth = '{16'd16, 16'd16, 16'd24, 16'd8, 16'd0, 16'hFFFF, 16'd32, 16'd12};
		hdr.valid           = 1'b0;
		hdr.header_byte     = 8'h00;
		hdr.final_byte      = 1'b0;
		hdr.total_file_size = 64'd0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = 3'd0;
		pwdata  = 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers must read back their reset values.
		reg_access(1'b0, wavh_pkg::REG_RATE, 32'd0);
		reg_access(1'b0, wavh_pkg::REG_DEPTH, 32'd0);

		// Directed headers against the reset settings.
		idle_phase(0);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 44, NO_FLIP);
		send_wav(16000, 2, 16, 4, 400, 436, 444, 44, NO_FLIP);
		send_wav(16000, 2, 16, 4, 8, 44, 52, 49, NO_FLIP);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 1, NO_FLIP);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 43, NO_FLIP);
		send_wav(16000, 1, 16, 2, 0, 36, 44, 44, NO_FLIP);
		send_wav(16000, 2, 16, 4, 6, 42, 50, 44, NO_FLIP);
		send_wav(16000, 3, 16, 6, 6, 42, 50, 44, NO_FLIP);
		send_wav(16000, 2, 16, 2, 8, 44, 52, 44, NO_FLIP);
		send_wav(44100, 1, 16, 2, 2, 38, 46, 44, NO_FLIP);
		send_wav(16000, 1, 24, 3, 3, 39, 47, 44, NO_FLIP);
		send_wav(16000, 1, 16, 2, 2, 37, 46, 44, NO_FLIP);
		send_wav(16000, 1, 16, 2, 2, 39, 47, 44, NO_FLIP);
		send_wav(16000, 1, 16, 2, 2, 0, 8, 44, NO_FLIP);
		send_wav(16000, 1, 16, 2, 2, 38, 64'h8000_0000_0000_002E, 44, NO_FLIP);
		// A data length near the top whose RIFF size still fits, then one where it wraps.
		send_wav(16000, 1, 16, 2, 32'hFFFF_FFD0, 32'hFFFF_FFF4, 64'hFFFF_FFFC, 44, NO_FLIP);
		send_wav(16000, 1, 16, 2, 32'hFFFF_FFFE, 32'h0000_0022, 64'h1_0000_002A, 44, NO_FLIP);
		// Damaged magic words, format chunk length and format tag.
		send_wav(16000, 1, 16, 2, 2, 38, 46, 44, 0);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 44, 39);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 44, 16);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 44, 20);
		send_wav(16000, 1, 16, 2, 2, 38, 46, 44, SCRAMBLE);

		// Random headers under a series of register settings, extremes included.
		for (int s = 0; s < 8; s++) begin
			set_registers(set_rate[s], set_depth[s]);
			mark = bytes_sent;
			n    = 0;
			while (bytes_sent - mark < BYTES_PER_SET || n < HDRS_PER_SET) begin
				idle_phase((n / 3 + s) % 4);
				random_header();
				n++;
				// Hold the sender once until every verdict is out.
				if (s == 3 && n == 2)
					drain();
			end
		end
		drain();

		$display("Run covered %0d header bytes under %0d register settings.",
			bytes_sent, settings);
		$display("%0d verdicts were checked, %0d of them on accepted headers.",
			verdict_count, accept_count);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS wav_header_validator_top");
		end else begin
			$display("FAIL wav_header_validator_top");
		end
		$finish;
	end

endmodule
